[hw/rtl/eds_pkg.sv]
// ----------------------------------------------------------------------------
// eds_pkg: shared types and constants of the edit distance block
// Field widths, function codes and the word passed along the cell chain.
// ----------------------------------------------------------------------------
package eds_pkg;

   // default longest string held by the chain
   localparam int MAX_LEN_DEF = 32;

   // field widths
   localparam int FUNC_W = 2;
   localparam int CH_W   = 8;
   localparam int DIST_W = 6;
   localparam int FRAC_W = 16;
   localparam int SIM_W  = 17;

   // similarity of two empty strings (1.0 in 1.16 fixed point)
   localparam logic [SIM_W-1:0] SIM_ONE = SIM_W'(1) << FRAC_W;

   // function codes of a request word
   localparam logic [FUNC_W-1:0] FUNC_FIRST  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_SECOND = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FINISH = 2'd2;

   // wavefront word handed from one cell to the next
   typedef struct packed {
      logic              valid;
      logic [CH_W-1:0]   ch;
      logic [DIST_W-1:0] d_left;   // new distance of the left neighbor
      logic [DIST_W-1:0] d_diag;   // old distance of the left neighbor
   } token_type;

endpackage

[hw/rtl/eds_req_if.sv]
// ----------------------------------------------------------------------------
// eds_req_if: request channel of the edit distance block
// Carries a function code and a character byte with valid/ready.
// ----------------------------------------------------------------------------
interface eds_req_if;
   logic                       valid;
   logic                       ready;
   logic [eds_pkg::FUNC_W-1:0] func;
   logic [eds_pkg::CH_W-1:0]   ch;

   modport source (output valid, output func, output ch, input ready);
   modport sink   (input valid, input func, input ch, output ready);
endinterface

[hw/rtl/eds_rsp_if.sv]
// ----------------------------------------------------------------------------
// eds_rsp_if: response channel of the edit distance block
// Carries distance, longer length, similarity and error with valid/ready.
// ----------------------------------------------------------------------------
interface eds_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [eds_pkg::DIST_W-1:0] distance;
   logic [eds_pkg::DIST_W-1:0] longer_len;
   logic [eds_pkg::SIM_W-1:0]  similarity;
   logic                       error;

   modport source (output valid, output distance, output longer_len,
                   output similarity, output error, input ready);
   modport sink   (input valid, input distance, input longer_len,
                   input similarity, input error, output ready);
endinterface

[hw/rtl/eds_cell.sv]
// ----------------------------------------------------------------------------
// eds_cell: one column of the distance row
// Holds one first-string character and its distance entry, updates the entry
// when a wavefront word arrives and passes the word on in the next cycle.
// ----------------------------------------------------------------------------
module eds_cell #(
   parameter int INDEX = 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  logic                       load_en,
   input  logic [eds_pkg::CH_W-1:0]   load_ch,
   input  eds_pkg::token_type         tok_in,
   output eds_pkg::token_type         tok_out,
   output logic [eds_pkg::DIST_W-1:0] dist_out
);

   logic [eds_pkg::CH_W-1:0]   ch_ff;
   logic [eds_pkg::DIST_W-1:0] dist_ff;
   logic [eds_pkg::DIST_W-1:0] dist_in;
   eds_pkg::token_type         tok_ff;
   eds_pkg::token_type         tok_in_next;
   logic [eds_pkg::DIST_W:0]   up_cost;
   logic [eds_pkg::DIST_W:0]   left_cost;
   logic [eds_pkg::DIST_W:0]   diag_cost;
   logic [eds_pkg::DIST_W:0]   best;

   // three edit paths and their minimum
   always_comb begin
      up_cost   = {1'b0, dist_ff} + (eds_pkg::DIST_W+1)'(1);
      left_cost = {1'b0, tok_in.d_left} + (eds_pkg::DIST_W+1)'(1);
      diag_cost = {1'b0, tok_in.d_diag}
                + (eds_pkg::DIST_W+1)'(ch_ff != tok_in.ch);
      best = (up_cost < left_cost) ? up_cost : left_cost;
      if (diag_cost < best) begin
         best = diag_cost;
      end
   end

   // next distance entry and word for the right neighbor
   always_comb begin
      if (clear) begin
         dist_in = eds_pkg::DIST_W'(INDEX);
      end else if (tok_in.valid) begin
         dist_in = best[eds_pkg::DIST_W-1:0];
      end else begin
         dist_in = dist_ff;
      end
      tok_in_next.valid  = tok_in.valid;
      tok_in_next.ch     = tok_in.ch;
      tok_in_next.d_left = best[eds_pkg::DIST_W-1:0];
      tok_in_next.d_diag = dist_ff;
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dist_ff      <= eds_pkg::DIST_W'(INDEX);
         tok_ff.valid <= 1'b0;
      end else begin
         dist_ff <= dist_in;
         tok_ff  <= tok_in_next;
      end
   end

   // character store
   always_ff @(posedge clock) begin
      if (load_en) begin
         ch_ff <= load_ch;
      end
   end

   assign tok_out  = tok_ff;
   assign dist_out = dist_ff;

endmodule

[hw/rtl/eds_div.sv]
// ----------------------------------------------------------------------------
// eds_div: restoring divider for the similarity fraction
// Divides numer * 2^16 by denom, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module eds_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [eds_pkg::DIST_W-1:0] numer,
   input  logic [eds_pkg::DIST_W-1:0] denom,
   output logic                       done,
   output logic [eds_pkg::SIM_W-1:0]  quotient
);

   localparam int DVD_W = eds_pkg::DIST_W + eds_pkg::FRAC_W;
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [DVD_W-1:0]           dvd_ff, dvd_in;
   logic [DVD_W-1:0]           quo_ff, quo_in;
   logic [eds_pkg::DIST_W-1:0] rem_ff, rem_in;
   logic [eds_pkg::DIST_W-1:0] den_ff, den_in;
   logic [eds_pkg::DIST_W:0]   trial;
   logic [eds_pkg::DIST_W:0]   diff;
   logic                       fits;

   // one restoring step
   always_comb begin
      trial = {rem_ff, dvd_ff[DVD_W-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = trial >= {1'b0, den_ff};
   end

   // step sequencing
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DVD_W);
         dvd_in  = {numer, {eds_pkg::FRAC_W{1'b0}}};
         quo_in  = '0;
         rem_in  = '0;
         den_in  = denom;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         quo_in = {quo_ff[DVD_W-2:0], fits};
         rem_in = fits ? diff[eds_pkg::DIST_W-1:0] : trial[eds_pkg::DIST_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[eds_pkg::SIM_W-1:0];

endmodule

[hw/rtl/edit_distance_similarity.sv]
// ----------------------------------------------------------------------------
// edit_distance_similarity: Levenshtein distance and similarity of two strings
// A chain of MAX_LEN cells holds the first string and the distance row; each
// second-string character runs through the chain as a wavefront.
// ----------------------------------------------------------------------------
// Usage:
//   req_in carries words of func and ch. func 0 stores ch as the next
//   first-string character, func 1 sends ch as the next second-string
//   character into the cell chain (back to back), func 2 finishes,
//   func 3 is taken and ignored. Characters past MAX_LEN,
//   and first-string characters after the second string has begun, are
//   dropped and set the error bit of the next response.
//   A finish word waits for the wavefront to leave the chain, then a
//   bit-serial divider forms the similarity and the response is loaded
//   into the output register; req_in.ready stays low until that load.
//   The finish also clears both strings.
//   response output register: a response waiting on rsp_out.ready does not
//   stop character words; a further finish holds in its last step until
//   the register is free.
//   reset (synchronous) empties both strings, clears the error flag and any
//   pending response.
// ----------------------------------------------------------------------------
module edit_distance_similarity #(
   parameter int MAX_LEN = eds_pkg::MAX_LEN_DEF
) (
   input  logic     clock,
   input  logic     reset,
   eds_req_if.sink  req_in,
   eds_rsp_if.source rsp_out
);

   localparam int IDX_W = $clog2(MAX_LEN + 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DRAIN  = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_EMIT   = 4'b1000
   } state_type;

   state_type                  state_ff, state_in;
   logic [IDX_W-1:0]           first_len_ff, first_len_in;
   logic [IDX_W-1:0]           second_len_ff, second_len_in;
   logic                       error_ff, error_in;
   logic [eds_pkg::DIST_W-1:0] dist_ff, dist_in;
   logic [eds_pkg::DIST_W-1:0] longer_ff, longer_in;
   logic                       rerr_ff, rerr_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [eds_pkg::DIST_W-1:0] rsp_dist_ff;
   logic [eds_pkg::DIST_W-1:0] rsp_longer_ff;
   logic [eds_pkg::SIM_W-1:0]  rsp_sim_ff;
   logic                       rsp_err_ff;

   eds_pkg::token_type         tok [0:MAX_LEN];
   logic [eds_pkg::DIST_W-1:0] row [0:MAX_LEN];
   logic [MAX_LEN-1:0]         in_flight;

   logic                       accept;
   logic                       push_first;
   logic                       push_second;
   logic                       drop;
   logic                       drain_done;
   logic                       clear;
   logic                       rsp_load;
   logic [IDX_W-1:0]           longer_len;
   logic [eds_pkg::DIST_W-1:0] longer_ext;
   logic [eds_pkg::DIST_W-1:0] dist_sel;
   logic [eds_pkg::DIST_W-1:0] same;
   logic                       div_done;
   logic [eds_pkg::SIM_W-1:0]  quotient;

   // request decode
   always_comb begin
      accept      = req_in.valid & req_in.ready;
      push_first  = accept && (req_in.func == eds_pkg::FUNC_FIRST)
                 && (second_len_ff == '0) && (first_len_ff != IDX_W'(MAX_LEN));
      push_second = accept && (req_in.func == eds_pkg::FUNC_SECOND)
                 && (second_len_ff != IDX_W'(MAX_LEN));
      drop        = accept && (((req_in.func == eds_pkg::FUNC_FIRST) && !push_first)
                 || ((req_in.func == eds_pkg::FUNC_SECOND) && !push_second));
   end

   // wavefront word entering the first cell, row entry zero
   always_comb begin
      tok[0].valid  = push_second;
      tok[0].ch     = req_in.ch;
      tok[0].d_left = eds_pkg::DIST_W'(second_len_ff) + eds_pkg::DIST_W'(1);
      tok[0].d_diag = eds_pkg::DIST_W'(second_len_ff);
      row[0]        = eds_pkg::DIST_W'(second_len_ff);
   end

   // cell chain
   for (genvar i = 1; i <= MAX_LEN; i++) begin : g_cell
      eds_cell #(
         .INDEX (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .clear    (clear),
         .load_en  (push_first && (first_len_ff == IDX_W'(i - 1))),
         .load_ch  (req_in.ch),
         .tok_in   (tok[i-1]),
         .tok_out  (tok[i]),
         .dist_out (row[i])
      );
      assign in_flight[i-1] = tok[i].valid;
   end

   // final distance and longer length
   always_comb begin
      longer_len = (first_len_ff > second_len_ff) ? first_len_ff : second_len_ff;
      longer_ext = eds_pkg::DIST_W'(longer_len);
      dist_sel   = row[first_len_ff];
      same       = (longer_ext >= dist_sel) ? (longer_ext - dist_sel) : '0;
   end

   // similarity divider
   eds_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (drain_done),
      .numer    (same),
      .denom    (longer_ext),
      .done     (div_done),
      .quotient (quotient)
   );

   // finish sequencer
   always_comb begin
      state_in   = state_ff;
      drain_done = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_in.func == eds_pkg::FUNC_FINISH)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (in_flight == '0) begin
               drain_done = 1'b1;
               state_in   = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_out.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      clear = drain_done;
   end

   // string lengths, error flag and captured result
   always_comb begin
      first_len_in  = first_len_ff;
      second_len_in = second_len_ff;
      error_in      = error_ff;
      dist_in       = dist_ff;
      longer_in     = longer_ff;
      rerr_in       = rerr_ff;
      if (clear) begin
         first_len_in  = '0;
         second_len_in = '0;
         error_in      = 1'b0;
         dist_in       = dist_sel;
         longer_in     = longer_ext;
         rerr_in       = error_ff;
      end else begin
         if (push_first) begin
            first_len_in = first_len_ff + IDX_W'(1);
         end
         if (push_second) begin
            second_len_in = second_len_ff + IDX_W'(1);
         end
         if (drop) begin
            error_in = 1'b1;
         end
      end
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_out.ready ? 1'b0 : rsp_valid_ff);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         first_len_ff  <= '0;
         second_len_ff <= '0;
         error_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         first_len_ff  <= first_len_in;
         second_len_ff <= second_len_in;
         error_ff      <= error_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // captured result and response word
   always_ff @(posedge clock) begin
      dist_ff   <= dist_in;
      longer_ff <= longer_in;
      rerr_ff   <= rerr_in;
      if (rsp_load) begin
         rsp_dist_ff   <= dist_ff;
         rsp_longer_ff <= longer_ff;
         rsp_sim_ff    <= (longer_ff == '0) ? eds_pkg::SIM_ONE : quotient;
         rsp_err_ff    <= rerr_ff;
      end
   end

   // channel outputs
   assign req_in.ready       = (state_ff == ST_IDLE);
   assign rsp_out.valid      = rsp_valid_ff;
   assign rsp_out.distance   = rsp_dist_ff;
   assign rsp_out.longer_len = rsp_longer_ff;
   assign rsp_out.similarity = rsp_sim_ff;
   assign rsp_out.error      = rsp_err_ff;

endmodule
